@@ src/cdq_pkg.sv @@
// cdq_pkg: shared types and constants for the circular deque core
// operation and status codes, controller states and command struct
// no dependencies
package cdq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int VALUE_W       = 32;
  localparam int KIND_W        = 2;
  localparam int STATUS_W      = 2;
  localparam int OCC_W         = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_LEFT  = 2'd0,
    KIND_PUSH_RIGHT = 2'd1,
    KIND_POP_LEFT   = 2'd2,
    KIND_POP_RIGHT  = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_EMIT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic take;  // capture the incoming beat
    logic exec;  // run the operation on pointers and store
    logic emit;  // load the result register
  } cdq_cmd_t;

endpackage

@@ src/cdq_if.sv @@
// cdq request and response channel interfaces
// valid/ready handshake with the deque payload fields
// depends on cdq_pkg for field widths
interface cdq_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [cdq_pkg::KIND_W-1:0]           kind;
  logic signed [cdq_pkg::VALUE_W-1:0]   push_value;

  modport source (output valid, output kind, output push_value, input ready);
  modport sink   (input valid, input kind, input push_value, output ready);
endinterface

interface cdq_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [cdq_pkg::STATUS_W-1:0]         status;
  logic signed [cdq_pkg::VALUE_W-1:0]   popped_value;
  logic [cdq_pkg::OCC_W-1:0]            occupancy;

  modport source (output valid, output status, output popped_value, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input popped_value, input occupancy,
                  output ready);
endinterface

@@ src/circular_deque_core.sv @@
// circular_deque_core: top level of the double-ended queue
// joins cdq_ctrl and cdq_datapath to the request and response channels
// depends on cdq_pkg, cdq_if, cdq_ctrl, cdq_datapath
//
// A double-ended queue of DEPTH signed 32-bit words kept in a ring with a
// left and a right end pointer. Each request beat carries one operation
// (push left, push right, pop left, pop right) and yields exactly one
// response beat with status, popped value and the occupancy after the
// operation. A push to a full deque reports overflow, a pop from an empty
// deque reports underflow; neither changes the contents. The request beat is
// captured at acceptance, the operation executes on the next edge with a
// registered ring store read, and the result register is then loaded once
// it is free or its beat drains; that load offers the response beat.
// The next request is accepted as soon as the previous result is loaded,
// while that result waits to be taken; a stalled response holds the block
// in its result-load step.
// No clearing pass is needed after reset.
module circular_deque_core #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
  input logic clk,
  input logic rst,
  cdq_req_if.sink   req,
  cdq_rsp_if.source rsp
);
  import cdq_pkg::*;

  cdq_cmd_t cmd;

  // sequencing
  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  // storage and pointer arithmetic
  cdq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .kind         (req.kind),
    .push_value   (req.push_value),
    .status       (rsp.status),
    .popped_value (rsp.popped_value),
    .occupancy    (rsp.occupancy)
  );

`ifndef SYNTH
  // only one command step at a time
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.take, cmd.exec, cmd.emit}))
    else $error("more than one command step active");

  // an accepted beat blocks the next one for the following cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while an operation is in flight");

  // failed operations return zero
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status == ST_OVERFLOW || rsp.status == ST_UNDERFLOW))
      |-> (rsp.popped_value == '0))
    else $error("failed operation returned a nonzero value");

  // underflow only happens on an empty deque, which stays empty
  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_UNDERFLOW) |-> (rsp.occupancy == '0))
    else $error("underflow reported with elements held");
`endif

endmodule

@@ src/cdq_ctrl.sv @@
// cdq_ctrl: sequencing state machine of the deque core
// drives request ready, response valid and datapath commands
// depends on cdq_pkg
module cdq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output cdq_pkg::cdq_cmd_t cmd
);
  import cdq_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.take   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        // wait until the result register is free or drains this cycle
        if (!rsp_valid || rsp_ready) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // response valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

@@ src/cdq_datapath.sv @@
// cdq_datapath: ring store, end pointers, element count and result register
// acts on commands from cdq_ctrl
// depends on cdq_pkg
module cdq_datapath #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  cdq_pkg::cdq_cmd_t                   cmd,
  input  logic [cdq_pkg::KIND_W-1:0]          kind,
  input  logic signed [cdq_pkg::VALUE_W-1:0]  push_value,
  output logic [cdq_pkg::STATUS_W-1:0]        status,
  output logic signed [cdq_pkg::VALUE_W-1:0]  popped_value,
  output logic [cdq_pkg::OCC_W-1:0]           occupancy
);
  import cdq_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  // captured operation
  kind_t               op_kind;
  logic [VALUE_W-1:0]  op_value;

  // deque state
  logic [PTR_W-1:0]    left_ptr, right_ptr;
  logic [CNT_W-1:0]    count;
  logic [VALUE_W-1:0]  ring [DEPTH];
  logic [VALUE_W-1:0]  rd_data;
  status_t             res_status;
  logic                pop_ok;

  logic [PTR_W-1:0]    left_up, left_dn, right_up, right_dn;
  logic [PTR_W-1:0]    wr_addr, rd_addr;
  logic                is_push, empty, full, wr_en;
  logic [CNT_W+OCC_W-1:0] count_wide;

  // capture the request beat
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_kind  <= kind_t'(kind);
      op_value <= push_value;
    end
  end

  // neighbor slots with wrap
  assign left_up  = (left_ptr  == PTR_LAST) ? '0 : left_ptr + 1'b1;
  assign left_dn  = (left_ptr  == '0) ? PTR_LAST : left_ptr - 1'b1;
  assign right_up = (right_ptr == PTR_LAST) ? '0 : right_ptr + 1'b1;
  assign right_dn = (right_ptr == '0) ? PTR_LAST : right_ptr - 1'b1;

  assign is_push = (op_kind == KIND_PUSH_LEFT) || (op_kind == KIND_PUSH_RIGHT);
  assign empty   = (count == '0);
  assign full    = (count == CNT_FULL);
  assign wr_en   = cmd.exec && is_push && !full;

  // store address for a push: first element lands on the left slot
  always_comb begin
    if (empty) begin
      wr_addr = left_ptr;
    end else if (op_kind == KIND_PUSH_LEFT) begin
      wr_addr = left_dn;
    end else begin
      wr_addr = right_up;
    end
  end

  assign rd_addr = (op_kind == KIND_POP_LEFT) ? left_ptr : right_ptr;

  // ring store write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[wr_addr] <= op_value;
    end
  end

  // ring store read port, registered
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd_data <= ring[rd_addr];
    end
  end

  // pointer and count update
  always_ff @(posedge clk) begin
    if (rst) begin
      left_ptr  <= '0;
      right_ptr <= '0;
      count     <= '0;
    end else if (cmd.exec) begin
      if (is_push) begin
        if (!full) begin
          if (empty) begin
            right_ptr <= left_ptr;
          end else if (op_kind == KIND_PUSH_LEFT) begin
            left_ptr <= left_dn;
          end else begin
            right_ptr <= right_up;
          end
          count <= count + 1'b1;
        end
      end else if (!empty) begin
        // the last element leaves both pointers in place
        if (count != CNT_ONE) begin
          if (op_kind == KIND_POP_LEFT) begin
            left_ptr <= left_up;
          end else begin
            right_ptr <= right_dn;
          end
        end
        count <= count - 1'b1;
      end
    end
  end

  // outcome of the operation
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      pop_ok <= !is_push && !empty;
      if (is_push && full) begin
        res_status <= ST_OVERFLOW;
      end else if (!is_push && empty) begin
        res_status <= ST_UNDERFLOW;
      end else begin
        res_status <= ST_DONE;
      end
    end
  end

  // occupancy reported modulo the field width
  assign count_wide = {{OCC_W{1'b0}}, count};

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status       <= res_status;
      popped_value <= pop_ok ? rd_data : '0;
      occupancy    <= count_wide[OCC_W-1:0];
    end
  end

endmodule
